/* rtl/svd_pkg.sv */
// Package for the soft-decision Viterbi decoder: sizes, register indexes and helpers.
// No dependencies.
package svd_pkg;
  localparam int StateBits  = 7;
  localparam int NumStates  = 1 << StateBits;
  localparam int MaxSteps   = 4096;
  localparam int SoftWidth  = 8;
  localparam int MetricW    = 24;
  localparam int StepW      = 13;
  localparam int AddrW      = 12;
  localparam int WordIdxW   = 6;

  localparam logic [1:0] RegPolyFirst   = 2'd0;
  localparam logic [1:0] RegPolySecond  = 2'd1;
  localparam logic [1:0] RegBlockLength = 2'd2;

  typedef logic [StateBits-1:0] state_t;
  typedef logic signed [MetricW-1:0] metric_t;

  function automatic logic parity7(input state_t g, input state_t s);
    parity7 = ^(g & s);
  endfunction
endpackage

/* rtl/svd_if.sv */
// Valid/ready channel interfaces for the Viterbi decoder.
// No dependencies.
interface svd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] soft_first;
  logic [7:0] soft_second;
  logic       end_of_block;
  modport source (output valid, soft_first, soft_second, end_of_block, input ready);
  modport sink (input valid, soft_first, soft_second, end_of_block, output ready);
endinterface

interface svd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] decoded_word;
  logic [5:0]  word_index;
  logic [6:0]  bit_count;
  logic        status;
  logic        final_word;
  modport source (output valid, decoded_word, word_index, bit_count, status, final_word,
                  input ready);
  modport sink (input valid, decoded_word, word_index, bit_count, status, final_word,
                output ready);
endinterface

interface svd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/svd_acs.sv */
// Shared add-compare-select unit, one state per cycle.
// Depends on svd_pkg.
module svd_acs import svd_pkg::*; (
  input  state_t                   poly_a_i,
  input  state_t                   poly_b_i,
  input  state_t                   state_i,
  input  logic signed [SoftWidth-1:0] soft_a_i,
  input  logic signed [SoftWidth-1:0] soft_b_i,
  input  metric_t                  old0_i,
  input  metric_t                  old1_i,
  output metric_t                  new_o,
  output logic                     take1_o
);
  metric_t ea, eb, edge_m, c0, c1;
  always_comb begin
    ea = MetricW'(soft_a_i);
    eb = MetricW'(soft_b_i);
    edge_m = (parity7(poly_a_i, state_i) ? ea : -ea) + (parity7(poly_b_i, state_i) ? eb : -eb);
    c0 = old0_i + edge_m;
    c1 = old1_i + edge_m;
    take1_o = c0 < c1;
    new_o = take1_o ? c1 : c0;
  end
endmodule

/* rtl/soft_viterbi_decoder_top.sv */
// Soft-decision Viterbi decoder, K=7, rate 1/2: sequencer, metric and survivor memories.
// Per pair: an accept state, StAcs streams 128 states through one shared ACS unit behind a
// registered metric read, then StCopy swaps banks; pairs are taken only in idle, so not
// before the last is through. An end_of_block adds a traceback that fetches, then consumes,
// a survivor row per step, and a fetch before each output word. Each block starts from zero
// metrics; rst_ni is async active low. Depends on svd_pkg, svd_if and svd_acs.
module soft_viterbi_decoder_top import svd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  svd_cfg_if.sink   cfg,
  svd_in_if.sink    in_ch,
  svd_out_if.source out_ch
);
  localparam logic [2:0] StIdle = 3'd0, StAcs = 3'd1, StCopy = 3'd2, StTbInit = 3'd3,
                         StTb = 3'd4, StOut = 3'd5, StShort = 3'd6;

  logic [2:0] st_q, st_d;
  state_t poly_a_q, poly_b_q;
  logic [11:0] blen_q;
  logic [StepW-1:0] cnt_q;
  logic [StepW-1:0] n_w;
  logic signed [SoftWidth-1:0] sa_q, sb_q;
  logic last_q;
  logic [StateBits:0] idx_q;
  logic bank_q;
  metric_t pm_mem [2*NumStates];
  metric_t pm_rd0_q, pm_rd1_q;
  metric_t old0, old1;
  logic [NumStates-1:0] surv_row_q;
  logic [NumStates-1:0] surv_mem [MaxSteps];
  logic [NumStates-1:0] surv_rd_q;
  logic [63:0] dbuf [64];
  logic [63:0] cur_word_q;
  logic [63:0] tb_word;
  logic [5:0] tb_bit;
  logic [StepW-1:0] k_q;
  state_t tst_q;
  logic [WordIdxW:0] w_q;
  logic [WordIdxW:0] nwords;
  logic [StepW-1:0] left;
  metric_t acs_new;
  logic acs_t1;
  state_t cur_s, base_s, acs_s;
  logic [63:0] rd_word_q;
  logic tb_pend_q;

  assign n_w = StepW'(blen_q) + StepW'(StateBits - 1);
  assign nwords = (WordIdxW+1)'((n_w + StepW'(63)) >> 6);
  assign cur_s = idx_q[StateBits-1:0];
  assign base_s = state_t'({cur_s[StateBits-2:0], 1'b0});
  // Metric reads are registered, so the ACS works one state behind.
  assign acs_s = state_t'(idx_q - (StateBits+1)'(1));
  assign old0 = (cnt_q == '0) ? '0 : pm_rd0_q;
  assign old1 = (cnt_q == '0) ? '0 : pm_rd1_q;

  svd_acs u_acs (
    .poly_a_i(poly_a_q), .poly_b_i(poly_b_q), .state_i(acs_s),
    .soft_a_i(sa_q), .soft_b_i(sb_q),
    .old0_i(old0), .old1_i(old1),
    .new_o(acs_new), .take1_o(acs_t1)
  );

  assign cfg.ready = (st_q == StIdle);
  assign in_ch.ready = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_a_q <= state_t'(91);
      poly_b_q <= state_t'(121);
      blen_q <= 12'd1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        RegPolyFirst:   poly_a_q <= state_t'(cfg.data[6:0]);
        RegPolySecond:  poly_b_q <= state_t'(cfg.data[6:0]);
        RegBlockLength: blen_q <= cfg.data;
        default: ;
      endcase
    end
  end

  // Path metrics: two banks of one entry per state; a pair reads one bank and writes the other.
  always_ff @(posedge clk_i) begin
    if (st_q == StAcs && idx_q != '0) pm_mem[{~bank_q, acs_s}] <= acs_new;
    pm_rd0_q <= pm_mem[{bank_q, base_s}];
    pm_rd1_q <= pm_mem[{bank_q, base_s | state_t'(1)}];
  end

  // Survivor memory: one row per trellis step, written after the ACS sweep.
  always_ff @(posedge clk_i) begin
    if (st_q == StCopy) surv_mem[cnt_q[AddrW-1:0]] <= surv_row_q;
    surv_rd_q <= surv_mem[k_q[AddrW-1:0] - AddrW'(1)];
  end

  assign tb_bit = 6'(k_q - StepW'(1));

  always_comb begin
    tb_word = cur_word_q;
    tb_word[tb_bit] = tst_q[StateBits-1];
  end

  always_ff @(posedge clk_i) begin
    rd_word_q <= dbuf[w_q[WordIdxW-1:0]];
    // A word is complete once its lowest bit has been traced.
    if (st_q == StTb && tb_pend_q && tb_bit == 6'd0)
      dbuf[WordIdxW'((k_q - StepW'(1)) >> 6)] <= tb_word;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_ch.valid) begin
        if (cnt_q < n_w && cnt_q < StepW'(MaxSteps)) st_d = StAcs;
        else if (in_ch.end_of_block) st_d = (cnt_q < n_w) ? StShort : StTbInit;
      end
      StAcs: if (idx_q == (StateBits+1)'(NumStates)) st_d = StCopy;
      StCopy: if (!last_q) st_d = StIdle;
              else st_d = (cnt_q + StepW'(1) < n_w) ? StShort : StTbInit;
      StTbInit: st_d = StTb;
      StTb: if (k_q == '0 && !tb_pend_q) st_d = StOut;
      StOut: if (out_ch.ready && w_q + 1'b1 == nwords && tb_pend_q) st_d = StIdle;
      StShort: if (out_ch.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      idx_q <= '0;
      last_q <= 1'b0;
      k_q <= '0;
      w_q <= '0;
      tb_pend_q <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StIdle: begin
          idx_q <= '0;
          last_q <= in_ch.end_of_block;
          sa_q <= in_ch.soft_first;
          sb_q <= in_ch.soft_second;
        end
        StAcs: begin
          if (idx_q != '0) surv_row_q[acs_s] <= acs_t1;
          idx_q <= idx_q + 1'b1;
        end
        StCopy: begin
          bank_q <= ~bank_q;
          idx_q <= '0;
          cnt_q <= cnt_q + StepW'(1);
        end
        StTbInit: begin
          k_q <= n_w;
          tb_pend_q <= 1'b0;
          cur_word_q <= '0;
        end
        StTb: begin
          // Alternate: fetch the survivor row, then consume it.
          if (k_q == '0) begin
            w_q <= '0;
          end else if (!tb_pend_q) begin
            tb_pend_q <= 1'b1;
            // The first fetch also picks the start state from the final metrics.
            if (k_q == n_w) tst_q <= (pm_rd0_q < pm_rd1_q) ? state_t'(1) : state_t'(0);
          end else begin
            tb_pend_q <= 1'b0;
            cur_word_q <= (tb_bit == 6'd0) ? '0 : tb_word;
            tst_q <= state_t'({tst_q[StateBits-2:0], surv_rd_q[tst_q]});
            k_q <= k_q - StepW'(1);
          end
        end
        StOut: begin
          if (!tb_pend_q) tb_pend_q <= 1'b1;
          else if (out_ch.ready) begin
            w_q <= w_q + 1'b1;
            tb_pend_q <= 1'b0;
            if (w_q + 1'b1 == nwords) cnt_q <= '0;
          end
        end
        StShort: if (out_ch.ready) begin
          cnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Word bits written at or above the valid count are never set, so masking is implicit.
  always_comb begin
    left = n_w - StepW'({w_q, 6'd0});
    out_ch.valid = (st_q == StShort) || (st_q == StOut && tb_pend_q);
    out_ch.status = (st_q == StShort);
    out_ch.final_word = (st_q == StShort) || (w_q + 1'b1 == nwords);
    out_ch.decoded_word = (st_q == StShort) ? 64'd0 : rd_word_q;
    out_ch.word_index = (st_q == StShort) ? '0 : w_q[WordIdxW-1:0];
    out_ch.bit_count = (st_q == StShort) ? 7'd0 :
                       ((left > StepW'(64)) ? 7'd64 : 7'(left));
  end

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.ready |-> in_ch.ready) else $error("cfg accepted while busy");
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !in_ch.ready) else $error("output while idle");
  a_short_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.status) |-> out_ch.final_word) else $error("short not final");
endmodule
